@@ rtl/core/tmpf_pkg.sv @@
package tmpf_pkg;

	localparam int STORE_AW       = 16;
	localparam int STORE_DEPTH    = 1 << STORE_AW;
	localparam int RSP_FIFO_DEPTH = 8;
	localparam int CFG_AW         = 5;

	typedef enum logic [1:0] {
		FUNC_WORD   = 2'd0,
		FUNC_INDEX  = 2'd1,
		FUNC_PAL    = 2'd2,
		FUNC_RENDER = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_TILE   = 2'd0,
		MODE_PALBMP = 2'd1,
		MODE_DIRECT = 2'd2,
		MODE_NONE   = 2'd3
	} layer_mode_t;

	typedef enum logic [2:0] {
		REG_LAYER_MODE    = 3'd0,
		REG_EXTENT_WIDTH  = 3'd1,
		REG_EXTENT_HEIGHT = 3'd2,
		REG_BRIGHTNESS    = 3'd3,
		REG_SWAP_RB       = 3'd4
	} reg_idx_t;

	localparam logic [8:0] EXTENT_RST     = 9'd32;
	localparam logic [8:0] BRIGHTNESS_MAX = 9'd256;

	localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;
	localparam logic [4:0] CHAN_MAX       = 5'h1f;

	typedef struct packed {
		layer_mode_t layer_mode;
		logic [8:0]  extent_width;
		logic [8:0]  extent_height;
		logic [8:0]  brightness_q8;
		logic        swap_red_blue;
	} cfg_t;

	typedef struct packed {
		logic [31:0] argb;
		logic        transparent;
		logic        outside;
	} rsp_t;

endpackage

@@ rtl/core/tmpf_if.sv @@
interface tmpf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] addr;
	logic [15:0] wdata;
	logic [7:0]  pix_x;
	logic [7:0]  pix_y;

	modport source (output valid, func, addr, wdata, pix_x, pix_y, input ready);
	modport sink   (input valid, func, addr, wdata, pix_x, pix_y, output ready);
endinterface

interface tmpf_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] argb;
	logic        transparent;
	logic        outside;

	modport source (output valid, argb, transparent, outside, input ready);
	modport sink   (input valid, argb, transparent, outside, output ready);
endinterface

@@ rtl/core/tile_map_pixel_fetch_top.sv @@
// Background layer pixel fetch.
// req carries one beat per operation: func selects a write to the word store,
// the index store or the palette (addr, wdata), or a render of pixel
// (pix_x, pix_y). Writes give no response; each render gives one rsp beat
// with argb, transparent and outside, in request order.
// The APB port holds layer_mode, extents, brightness and red/blue swap at
// byte addresses 0, 4, 8, 12, 16; write it only while no render is pending.
// Pipeline: word store read in the accept cycle, tile divide, index store
// read, palette read, color convert. While rsp is ready, one beat per
// cycle is sustained; a stalled rsp can drop req.ready.
// Each store is read and written at a single fixed stage, so a write is
// always seen by any later render.
// Results collect in an 8 entry output FIFO; req.ready drops only when the
// FIFO plus renders in flight would overfill it, so a stalled rsp blocks req
// after a few beats and no result is lost.
// Reset clears the registers to mode tile map, extents 32, brightness 256,
// no swap, and empties the pipeline; store contents are undefined until
// written.
module tile_map_pixel_fetch_top import tmpf_pkg::*; #(
	parameter int TILE_SIZE          = 8,
	parameter int SHEET_TILES_ACROSS = 16,
	parameter int MAP_SPAN           = 32,
	parameter int PIXEL_SPAN         = 256,
	parameter int PALETTE_SIZE       = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	tmpf_req_if.sink          req,
	tmpf_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int TRW       = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
	localparam int PAW       = $clog2(PALETTE_SIZE);
	localparam int DivL      = $clog2(SHEET_TILES_ACROSS);
	localparam int DivSh     = STORE_AW + DivL;
	localparam int DivM      = ((1 << DivSh) + SHEET_TILES_ACROSS - 1) / SHEET_TILES_ACROSS;
	localparam int SheetW    = SHEET_TILES_ACROSS * TILE_SIZE;
	localparam int SheetK    = SheetW * (TILE_SIZE - 1);
	localparam int FCW       = $clog2(RSP_FIFO_DEPTH + 1);

	cfg_t cfg;

	tmpf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// constant division tables for pixel coordinates and palette index wrap
	logic [7:0]     div_tab [256];
	logic [TRW-1:0] mod_tab [256];
	logic [PAW-1:0] pal_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_tab
		assign div_tab[i] = 8'(i / TILE_SIZE);
		assign mod_tab[i] = TRW'(i % TILE_SIZE);
		assign pal_tab[i] = PAW'(i % PALETTE_SIZE);
	end

	// stage 0: accept, extent test, word store access
	logic        in_fire;
	logic        outside_0;
	logic [15:0] ew_px, eh_px;
	logic [31:0] maddr_w, baddr_w;
	logic [15:0] word_raddr;
	logic [15:0] word_rd;
	logic [FCW:0] occupancy;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [1:0]  func_s1, func_s2, func_s3;
	logic [15:0] addr_s1, addr_s2, addr_s3;
	logic [15:0] wdata_s1, wdata_s2, wdata_s3;
	logic [TRW-1:0] rx_s1, ry_s1, rx_s2, ry_s2;
	logic [15:0] baddr_s1, baddr_s2;
	logic        outside_s1, outside_s2, outside_s3, outside_s4;
	logic [15:0] word_s2, word_s3, word_s4;
	logic [15:0] q_s2;

	logic [FCW-1:0] fifo_count;
	logic [2:0]     inflight;

	assign in_fire = req.valid & req.ready;

	assign inflight = 3'(v_s1 && func_s1 == FUNC_RENDER) + 3'(v_s2 && func_s2 == FUNC_RENDER)
		+ 3'(v_s3 && func_s3 == FUNC_RENDER) + 3'(v_s4);
	assign occupancy = (FCW+1)'(fifo_count) + (FCW+1)'(inflight);
	assign req.ready = (occupancy < (FCW+1)'(RSP_FIFO_DEPTH));

	assign ew_px = 16'(cfg.extent_width) * 16'(TILE_SIZE);
	assign eh_px = 16'(cfg.extent_height) * 16'(TILE_SIZE);

	always_comb begin
		case (cfg.layer_mode)
			MODE_TILE:   outside_0 = (16'(req.pix_x) >= ew_px) || (16'(req.pix_y) >= eh_px);
			MODE_PALBMP,
			MODE_DIRECT: outside_0 = (9'(req.pix_x) >= cfg.extent_width)
				|| (9'(req.pix_y) >= cfg.extent_height);
			default:     outside_0 = 1'b1;
		endcase
	end

	assign maddr_w = 32'(div_tab[req.pix_y]) * 32'(MAP_SPAN) + 32'(div_tab[req.pix_x]);
	assign baddr_w = 32'(req.pix_y) * 32'(PIXEL_SPAN) + 32'(req.pix_x);
	assign word_raddr = (cfg.layer_mode == MODE_TILE) ? maddr_w[15:0] : baddr_w[15:0];

	tmpf_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_word_ram (
		.clk   (clk),
		.we    (in_fire && req.func == FUNC_WORD),
		.waddr (req.addr),
		.wdata (req.wdata),
		.re    (1'b1),
		.raddr (word_raddr),
		.rdata (word_rd)
	);

	// stage 1: tile number divided by sheet width in tiles
	logic [32:0] qprod;

	assign qprod = 33'(word_rd) * 33'(DivM);

	// stage 2: tile sheet address, index store access
	logic [31:0] saddr_w;
	logic [15:0] index_raddr;
	logic [7:0]  index_rd;

	assign saddr_w = 32'(q_s2) * 32'(SheetK) + 32'(word_s2) * 32'(TILE_SIZE)
		+ 32'(ry_s2) * 32'(SheetW) + 32'(rx_s2);
	assign index_raddr = (cfg.layer_mode == MODE_TILE) ? saddr_w[15:0] : baddr_s2;

	tmpf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_index_ram (
		.clk   (clk),
		.we    (v_s2 && func_s2 == FUNC_INDEX),
		.waddr (addr_s2),
		.wdata (wdata_s2[7:0]),
		.re    (1'b1),
		.raddr (index_raddr),
		.rdata (index_rd)
	);

	// stage 3: palette access
	logic [15:0] pal_rd;

	tmpf_ram #(.WIDTH(16), .DEPTH(PALETTE_SIZE)) u_pal_ram (
		.clk   (clk),
		.we    (v_s3 && func_s3 == FUNC_PAL && addr_s3 < 16'(PALETTE_SIZE)),
		.waddr (addr_s3[PAW-1:0]),
		.wdata (wdata_s3),
		.re    (1'b1),
		.raddr (pal_tab[index_rd]),
		.rdata (pal_rd)
	);

	// stage 4: color convert into the output FIFO
	rsp_t color_rsp;
	rsp_t fifo_out;

	tmpf_color u_color (
		.color   ((cfg.layer_mode == MODE_DIRECT) ? word_s4 : pal_rd),
		.outside (outside_s4),
		.cfg     (cfg),
		.rsp     (color_rsp)
	);

	tmpf_fifo #(.WIDTH($bits(rsp_t)), .DEPTH(RSP_FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s4),
		.push_data (color_rsp),
		.pop       (rsp.ready),
		.pop_data  (fifo_out),
		.valid     (rsp.valid),
		.count     (fifo_count)
	);

	assign rsp.argb        = fifo_out.argb;
	assign rsp.transparent = fifo_out.transparent;
	assign rsp.outside     = fifo_out.outside;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && func_s3 == FUNC_RENDER;
		end
	end

	always_ff @(posedge clk) begin
		func_s1    <= req.func;
		addr_s1    <= req.addr;
		wdata_s1   <= req.wdata;
		rx_s1      <= mod_tab[req.pix_x];
		ry_s1      <= mod_tab[req.pix_y];
		baddr_s1   <= baddr_w[15:0];
		outside_s1 <= outside_0;

		func_s2    <= func_s1;
		addr_s2    <= addr_s1;
		wdata_s2   <= wdata_s1;
		rx_s2      <= rx_s1;
		ry_s2      <= ry_s1;
		baddr_s2   <= baddr_s1;
		outside_s2 <= outside_s1;
		word_s2    <= word_rd;
		q_s2       <= 16'(qprod >> DivSh);

		func_s3    <= func_s2;
		addr_s3    <= addr_s2;
		wdata_s3   <= wdata_s2;
		outside_s3 <= outside_s2;
		word_s3    <= word_s2;

		outside_s4 <= outside_s3;
		word_s4    <= word_s3;
	end

endmodule

@@ rtl/core/tmpf_ram.sv @@
module tmpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/tmpf_cfg.sv @@
module tmpf_cfg import tmpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layer_mode    <= MODE_TILE;
			cfg_q.extent_width  <= EXTENT_RST;
			cfg_q.extent_height <= EXTENT_RST;
			cfg_q.brightness_q8 <= BRIGHTNESS_MAX;
			cfg_q.swap_red_blue <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_LAYER_MODE:    cfg_q.layer_mode    <= layer_mode_t'(pwdata[1:0]);
				REG_EXTENT_WIDTH:  cfg_q.extent_width  <= pwdata[8:0];
				REG_EXTENT_HEIGHT: cfg_q.extent_height <= pwdata[8:0];
				REG_BRIGHTNESS:    cfg_q.brightness_q8 <= pwdata[8:0];
				REG_SWAP_RB:       cfg_q.swap_red_blue <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LAYER_MODE:    prdata = {30'd0, cfg_q.layer_mode};
			REG_EXTENT_WIDTH:  prdata = {23'd0, cfg_q.extent_width};
			REG_EXTENT_HEIGHT: prdata = {23'd0, cfg_q.extent_height};
			REG_BRIGHTNESS:    prdata = {23'd0, cfg_q.brightness_q8};
			REG_SWAP_RB:       prdata = {31'd0, cfg_q.swap_red_blue};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/core/tmpf_color.sv @@
module tmpf_color import tmpf_pkg::*; (
	input  logic [15:0] color,
	input  logic        outside,
	input  cfg_t        cfg,
	output rsp_t        rsp
);

	logic [4:0]  r_raw, g_raw, b_raw;
	logic [4:0]  r_sel, b_sel;
	logic [8:0]  k;
	logic [13:0] r_prod, g_prod, b_prod;
	logic        key;

	assign r_raw = color[14:10];
	assign g_raw = color[9:5];
	assign b_raw = color[4:0];
	assign key   = color[15] | (r_raw == CHAN_MAX && g_raw == 5'd0 && b_raw == CHAN_MAX);

	assign k     = (cfg.brightness_q8 > BRIGHTNESS_MAX) ? BRIGHTNESS_MAX : cfg.brightness_q8;
	assign r_sel = cfg.swap_red_blue ? b_raw : r_raw;
	assign b_sel = cfg.swap_red_blue ? r_raw : b_raw;

	assign r_prod = 14'(r_sel) * 14'(k);
	assign g_prod = 14'(g_raw) * 14'(k);
	assign b_prod = 14'(b_sel) * 14'(k);

	always_comb begin
		rsp.outside     = outside;
		rsp.transparent = 1'b0;
		rsp.argb        = 32'd0;
		if (!outside) begin
			if (key) begin
				rsp.transparent = 1'b1;
			end else begin
				rsp.argb = {ALPHA_OPAQUE, r_prod[12:8], 3'b000,
					g_prod[12:8], 3'b000, b_prod[12:8], 3'b000};
			end
		end
	end

endmodule

@@ rtl/core/tmpf_fifo.sv @@
module tmpf_fifo #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic                       valid,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign valid    = (count_q != '0);
	assign do_pop   = pop & valid;
	assign pop_data = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ dv/tile_map_pixel_fetch_top_tb.sv @@
`timescale 1ns / 1ps

import tmpf_pkg::*;

localparam int TILE_PX      = 8;
localparam int SHEET_ACROSS = 16;
localparam int MAP_PITCH    = 32;
localparam int BMP_PITCH    = 256;
localparam int PAL_ENTRIES  = 256;

localparam logic [15:0] KEY_MAGENTA = 16'h7C1F;

class pixel_ledger;
	cfg_t        regs;
	logic [15:0] map_words [STORE_DEPTH];
	logic [7:0]  sheet_bytes [STORE_DEPTH];
	logic [15:0] pal_colors [PAL_ENTRIES];
	bit          map_set [STORE_DEPTH];
	bit          sheet_set [STORE_DEPTH];
	bit          pal_set [PAL_ENTRIES];
	rsp_t        colors_due [$];
	int          bad_beats;
	int          pixels_seen;

	function new();
		regs.layer_mode    = MODE_TILE;
		regs.extent_width  = EXTENT_RST;
		regs.extent_height = EXTENT_RST;
		regs.brightness_q8 = BRIGHTNESS_MAX;
		regs.swap_red_blue = 1'b0;
		bad_beats          = 0;
		pixels_seen        = 0;
	endfunction

	function void set_reg(reg_idx_t r, logic [31:0] v);
		case (r)
			REG_LAYER_MODE:    regs.layer_mode    = layer_mode_t'(v[1:0]);
			REG_EXTENT_WIDTH:  regs.extent_width  = v[8:0];
			REG_EXTENT_HEIGHT: regs.extent_height = v[8:0];
			REG_BRIGHTNESS:    regs.brightness_q8 = v[8:0];
			REG_SWAP_RB:       regs.swap_red_blue = v[0];
			default: ;
		endcase
	endfunction

	function bit off_layer(logic [7:0] x, logic [7:0] y);
		int unsigned lim_x;
		int unsigned lim_y;
		lim_x = regs.extent_width;
		lim_y = regs.extent_height;
		if (regs.layer_mode == MODE_TILE) begin
			lim_x = lim_x * TILE_PX;
			lim_y = lim_y * TILE_PX;
		end
		return regs.layer_mode == MODE_NONE || x >= lim_x || y >= lim_y;
	endfunction

	function logic [15:0] map_slot(logic [7:0] x, logic [7:0] y);
		return 16'((y / TILE_PX) * MAP_PITCH + x / TILE_PX);
	endfunction

	function logic [15:0] sheet_index(logic [7:0] x, logic [7:0] y, logic [15:0] tile);
		int unsigned row;
		int unsigned col;
		row = (tile / SHEET_ACROSS) * TILE_PX + y % TILE_PX;
		col = (tile % SHEET_ACROSS) * TILE_PX + x % TILE_PX;
		return 16'(row * SHEET_ACROSS * TILE_PX + col);
	endfunction

	function logic [15:0] bmp_index(logic [7:0] x, logic [7:0] y);
		return 16'(y * BMP_PITCH + x);
	endfunction

	// first store entry on the fetch chain of (x,y) that holds nothing yet
	function bit find_gap(logic [7:0] x, logic [7:0] y, output func_t f,
			output logic [15:0] a);
		logic [15:0] m;
		logic [15:0] s;
		int          p;
		f = FUNC_WORD;
		a = '0;
		if (off_layer(x, y))
			return 0;
		case (regs.layer_mode)
			MODE_TILE: begin
				m = map_slot(x, y);
				if (!map_set[m]) begin
					a = m;
					return 1;
				end
				s = sheet_index(x, y, map_words[m]);
			end
			MODE_PALBMP: begin
				s = bmp_index(x, y);
			end
			default: begin
				m = bmp_index(x, y);
				if (!map_set[m]) begin
					a = m;
					return 1;
				end
				return 0;
			end
		endcase
		if (!sheet_set[s]) begin
			f = FUNC_INDEX;
			a = s;
			return 1;
		end
		p = sheet_bytes[s] % PAL_ENTRIES;
		if (!pal_set[p]) begin
			f = FUNC_PAL;
			a = 16'(p);
			return 1;
		end
		return 0;
	endfunction

	function logic [15:0] fetch_color(logic [7:0] x, logic [7:0] y);
		logic [7:0] idx;
		case (regs.layer_mode)
			MODE_TILE: begin
				idx = sheet_bytes[sheet_index(x, y, map_words[map_slot(x, y)])];
				return pal_colors[idx % PAL_ENTRIES];
			end
			MODE_PALBMP: begin
				idx = sheet_bytes[bmp_index(x, y)];
				return pal_colors[idx % PAL_ENTRIES];
			end
			default: return map_words[bmp_index(x, y)];
		endcase
	endfunction

	function rsp_t shade_pixel(logic [7:0] x, logic [7:0] y);
		rsp_t        o;
		logic [15:0] c;
		logic [4:0]  r;
		logic [4:0]  g;
		logic [4:0]  b;
		logic [4:0]  t;
		int unsigned k;
		o = '0;
		if (off_layer(x, y)) begin
			o.outside = 1'b1;
			return o;
		end
		c = fetch_color(x, y);
		r = c[14:10];
		g = c[9:5];
		b = c[4:0];
		if (c[15] || (r == CHAN_MAX && g == 5'd0 && b == CHAN_MAX)) begin
			o.transparent = 1'b1;
			return o;
		end
		if (regs.swap_red_blue) begin
			t = r;
			r = b;
			b = t;
		end
		k = (regs.brightness_q8 > BRIGHTNESS_MAX) ? BRIGHTNESS_MAX : regs.brightness_q8;
		r = 5'((r * k) >> 8);
		g = 5'((g * k) >> 8);
		b = 5'((b * k) >> 8);
		o.argb = {ALPHA_OPAQUE, r, 3'b000, g, 3'b000, b, 3'b000};
		return o;
	endfunction

	function void log_request(func_t f, logic [15:0] addr, logic [15:0] wdata,
			logic [7:0] x, logic [7:0] y);
		case (f)
			FUNC_WORD: begin
				map_words[addr] = wdata;
				map_set[addr]   = 1'b1;
			end
			FUNC_INDEX: begin
				sheet_bytes[addr] = wdata[7:0];
				sheet_set[addr]   = 1'b1;
			end
			FUNC_PAL: begin
				if (addr < PAL_ENTRIES) begin
					pal_colors[addr[7:0]] = wdata;
					pal_set[addr[7:0]]    = 1'b1;
				end
			end
			default: colors_due.push_back(shade_pixel(x, y));
		endcase
	endfunction

	function void note_bad(string msg);
		bad_beats++;
		if (bad_beats <= 10)
			$display("%s", msg);
	endfunction

	function void match_pixel(rsp_t got);
		rsp_t want;
		pixels_seen++;
		if (colors_due.size() == 0) begin
			note_bad($sformatf("pixel beat %0d with none pending: argb %h transparent %b outside %b",
				pixels_seen, got.argb, got.transparent, got.outside));
			return;
		end
		want = colors_due.pop_front();
		if (got.argb !== want.argb || got.transparent !== want.transparent ||
				got.outside !== want.outside)
			note_bad($sformatf("pixel beat %0d: want argb %h t %b o %b, got argb %h t %b o %b",
				pixels_seen, want.argb, want.transparent, want.outside,
				got.argb, got.transparent, got.outside));
	endfunction
endclass

module tile_map_pixel_fetch_top_tb;
	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                send_idle_pct;
	int                stall_pct;
	int                hold_ask;
	int                writes_sent;
	int                renders_sent;

	tmpf_req_if req_bus();
	tmpf_rsp_if rsp_bus();

	pixel_ledger ledger = new();

	tile_map_pixel_fetch_top #(
		.TILE_SIZE          (TILE_PX),
		.SHEET_TILES_ACROSS (SHEET_ACROSS),
		.MAP_SPAN           (MAP_PITCH),
		.PIXEL_SPAN         (BMP_PITCH),
		.PALETTE_SIZE       (PAL_ENTRIES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : rsp_side
		int left;
		left          = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != 0) begin
				left     = hold_ask;
				hold_ask = 0;
			end
			if (left > 0) begin
				left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			ledger.match_pixel({rsp_bus.argb, rsp_bus.transparent, rsp_bus.outside});

	function automatic logic [15:0] fill_data(func_t f);
		if (f == FUNC_INDEX)
			return 16'($urandom);
		case ($urandom_range(0, 7))
			0:       return KEY_MAGENTA;
			1:       return 16'h7FFF;
			2:       return {1'b1, 15'($urandom)};
			default: return {1'b0, 15'($urandom)};
		endcase
	endfunction

	function automatic logic [7:0] pick_coord(int lim);
		if (lim == 0 || $urandom_range(0, 4) == 0)
			return 8'($urandom);
		return 8'($urandom_range(0, (lim > 256 ? 256 : lim) - 1));
	endfunction

	task automatic send_item(input func_t f, input logic [15:0] a, input logic [15:0] w,
			input logic [7:0] x, input logic [7:0] y);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.func  <= f;
		req_bus.addr  <= a;
		req_bus.wdata <= w;
		req_bus.pix_x <= x;
		req_bus.pix_y <= y;
		do @(posedge clk); while (!req_bus.ready);
		ledger.log_request(f, a, w, x, y);
		if (f == FUNC_RENDER)
			renders_sent++;
		else
			writes_sent++;
	endtask

	// load whatever the fetch chain still lacks, then ask for the pixel
	task automatic render_pixel(input logic [7:0] x, input logic [7:0] y);
		func_t       f;
		logic [15:0] a;
		while (ledger.find_gap(x, y, f, a))
			send_item(f, a, fill_data(f), 8'($urandom), 8'($urandom));
		send_item(FUNC_RENDER, 16'($urandom), 16'($urandom), x, y);
	endtask

	task automatic apb_write(input reg_idx_t r, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.set_reg(r, v);
	endtask

	task automatic drain();
		req_bus.valid <= 1'b0;
		while (ledger.colors_due.size() != 0)
			@(posedge clk);
		// writes give no beat; let the 4-deep pipe empty
		repeat (10) @(posedge clk);
	endtask

	initial begin : stimulus
		cfg_t        cfg;
		func_t       f;
		logic [15:0] a;
		int          lim_x;
		int          lim_y;
		int          quota;
		req_bus.valid = 1'b0;
		req_bus.func  = FUNC_WORD;
		req_bus.addr  = '0;
		req_bus.wdata = '0;
		req_bus.pix_x = '0;
		req_bus.pix_y = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_ask      = 0;
		writes_sent   = 0;
		renders_sent  = 0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_PAL, 16'd0, KEY_MAGENTA, 8'd0, 8'd0);
		send_item(FUNC_PAL, 16'd1, 16'h8000, 8'hFF, 8'hFF);
		send_item(FUNC_PAL, 16'd2, 16'h7FFF, 8'h00, 8'hFF);
		send_item(FUNC_PAL, 16'd255, 16'h7C1E, 8'hFF, 8'h00);
		send_item(FUNC_PAL, 16'd256, 16'h1234, 8'h55, 8'hAA);
		send_item(FUNC_PAL, 16'hFFFF, 16'hFFFF, 8'hAA, 8'h55);
		send_item(FUNC_WORD, 16'd0, 16'h0000, 8'd0, 8'd0);
		send_item(FUNC_WORD, 16'd1023, 16'hFFFF, 8'd0, 8'd0);
		send_item(FUNC_INDEX, 16'd0, 16'h0002, 8'd0, 8'd0);
		send_item(FUNC_INDEX, 16'd1, 16'hFF00, 8'd0, 8'd0);
		send_item(FUNC_INDEX, 16'd2, 16'h0001, 8'd0, 8'd0);
		send_item(FUNC_INDEX, 16'd3, 16'hABFF, 8'd0, 8'd0);
		for (int i = 0; i < 4; i++)
			render_pixel(8'(i), 8'd0);
		render_pixel(8'd255, 8'd255);
		render_pixel(8'd0, 8'd255);

		for (int p = 0; p < 12; p++) begin
			drain();
			case (p)
				0:  cfg = '{MODE_TILE,   9'd32,  9'd32,  9'd256, 1'b0};
				1:  cfg = '{MODE_PALBMP, 9'd256, 9'd256, 9'd128, 1'b1};
				2:  cfg = '{MODE_DIRECT, 9'd256, 9'd256, 9'd256, 1'b0};
				3:  cfg = '{MODE_TILE,   9'd1,   9'd1,   9'd0,   1'b1};
				4:  cfg = '{MODE_DIRECT, 9'd100, 9'd60,  9'd511, 1'b1};
				5:  cfg = '{MODE_PALBMP, 9'd0,   9'd17,  9'd300, 1'b0};
				6:  cfg = '{MODE_NONE,   9'd255, 9'd255, 9'd200, 1'b1};
				7:  cfg = '{MODE_TILE,   9'd511, 9'd511, 9'd77,  1'b0};
				8:  cfg = '{MODE_TILE,   9'd20,  9'd25,  9'd256, 1'b1};
				default: begin
					cfg.layer_mode    = layer_mode_t'($urandom_range(0, 2));
					cfg.extent_width  = 9'($urandom_range(1, 256));
					cfg.extent_height = 9'($urandom_range(1, 256));
					cfg.brightness_q8 = 9'($urandom_range(0, 511));
					cfg.swap_red_blue = 1'($urandom);
				end
			endcase
			apb_write(REG_LAYER_MODE, 32'(cfg.layer_mode));
			apb_write(REG_EXTENT_WIDTH, 32'(cfg.extent_width));
			apb_write(REG_EXTENT_HEIGHT, 32'(cfg.extent_height));
			apb_write(REG_BRIGHTNESS, 32'(cfg.brightness_q8));
			apb_write(REG_SWAP_RB, 32'(cfg.swap_red_blue));
			psel    <= 1'b0;
			penable <= 1'b0;

			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 61;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 61;
				end
				default: begin
					send_idle_pct = 37;
					stall_pct     = 37;
				end
			endcase
			// long rsp stall with req still flowing: FIFO fills, req backs up
			if (p == 4 || p == 8)
				hold_ask = 250;

			lim_x = cfg.extent_width;
			lim_y = cfg.extent_height;
			if (cfg.layer_mode == MODE_TILE) begin
				lim_x = lim_x * TILE_PX;
				lim_y = lim_y * TILE_PX;
			end
			quota = writes_sent + renders_sent + 118;
			while (writes_sent + renders_sent < quota) begin
				if ($urandom_range(0, 99) < 20) begin
					f = func_t'($urandom_range(0, 2));
					if (f == FUNC_PAL && $urandom_range(0, 3) != 0)
						a = 16'($urandom_range(0, PAL_ENTRIES - 1));
					else
						a = 16'($urandom);
					send_item(f, a, fill_data(f), 8'($urandom), 8'($urandom));
				end else begin
					render_pixel(pick_coord(lim_x), pick_coord(lim_y));
				end
			end
		end
		drain();

		$display("Checked %0d pixel beats from %0d renders and %0d store writes over 12 layer settings",
			ledger.pixels_seen, renders_sent, writes_sent);
		$display("(all modes, empty and oversized extents, brightness 0 to 511, swap, keyed colors).");
		if (ledger.bad_beats == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ tile_map_pixel_fetch_top.f @@
rtl/core/tmpf_pkg.sv
rtl/core/tmpf_if.sv
rtl/core/tmpf_ram.sv
rtl/core/tmpf_cfg.sv
rtl/core/tmpf_color.sv
rtl/core/tmpf_fifo.sv
rtl/core/tile_map_pixel_fetch_top.sv
dv/tile_map_pixel_fetch_top_tb.sv
